### rtl/pth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_pkg
// Shared widths, fixed-point constants and register indexes for the
// flat-top hex grid picker.
// ----------------------------------------------------------------------------
package pth_pkg;

   // pointer coordinate width in whole pixels
   localparam int PIXEL_BITS = 12;

   // register port
   localparam int CSR_W      = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int ORIGIN_W   = 17;
   localparam int INV_W      = 16;
   localparam logic [INV_W-1:0] INV_RADIUS_RST = INV_W'(2048);

   // result width (axial coordinates wrap modulo 2^OUT_W)
   localparam int OUT_W = 14;

   // offset from origin, 4 fraction bits, signed
   localparam int DX_W = ((PIXEL_BITS + 4 > ORIGIN_W - 1) ?
                          (PIXEL_BITS + 4) : (ORIGIN_W - 1)) + 2;
   // scaled offset, 20 fraction bits, signed
   localparam int U_W  = DX_W + INV_W;
   // constants carry 20 fraction bits
   localparam int K_W  = 21;
   // single constant product, 40 fraction bits
   localparam int P_W  = U_W + K_W;
   // cube coordinates, room for the two-term and three-term sums
   localparam int F_W  = P_W + 2;
   localparam int FRAC = 40;

   localparam logic signed [K_W-1:0] K_TWO_THIRDS = 21'sd699051;
   localparam logic signed [K_W-1:0] K_ONE_THIRD  = 21'sd349525;
   localparam logic signed [K_W-1:0] K_INV_SQRT3  = 21'sd605396;

   // pipeline depth, input register to output register
   localparam int STAGES = 7;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X   = 2'd0,
      CSR_ORIGIN_Y   = 2'd1,
      CSR_INV_RADIUS = 2'd2
   } csr_index_type;

endpackage

### rtl/pth_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pth_if
// Valid/ready channels of the hex grid picker: pixel requests and
// axial cell responses.
// ----------------------------------------------------------------------------
interface pth_req_if;
   logic                            valid;
   logic                            ready;
   logic [pth_pkg::PIXEL_BITS-1:0]  pixel_x;
   logic [pth_pkg::PIXEL_BITS-1:0]  pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface pth_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pth_pkg::OUT_W-1:0]  hex_q;
   logic signed [pth_pkg::OUT_W-1:0]  hex_r;

   modport source (output valid, output hex_q, output hex_r, input ready);
   modport sink   (input valid, input hex_q, input hex_r, output ready);
endinterface

### rtl/pixel_to_hex_axial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_hex_axial
// Maps a pixel position to the axial (q, r) coordinates of the flat-top
// hex cell containing it, with cube rounding, as a 7-stage pipeline.
// ----------------------------------------------------------------------------
// a request registers in the first stage and its response leaves the last stage register
// throughput: one item per cycle while rsp_ch.ready is high; each stage
//    loads whenever it is empty or its successor moves, so the pipeline
//    compresses bubbles under stall
// the longest stage paths are the 34 x 21 constant multipliers in stage 3
// reset clears all stage valid bits and restores origin 0, inv_radius 2048
// ----------------------------------------------------------------------------
module pixel_to_hex_axial (
   input  logic                              clock,
   input  logic                              reset,
   pth_req_if.sink                           req_ch,
   pth_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [pth_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pth_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int ST   = pth_pkg::STAGES;
   localparam int FR   = pth_pkg::FRAC;
   localparam int OW   = pth_pkg::OUT_W;
   localparam int FW   = pth_pkg::F_W;
   localparam int PW   = pth_pkg::P_W;
   localparam int UW   = pth_pkg::U_W;
   localparam int DW   = pth_pkg::DX_W;
   localparam logic [FR:0] ONE_OUT = {1'b1, {FR{1'b0}}};

   // rounding error of a magnitude, from its fraction bits
   function automatic logic [FR:0] round_err(input logic [FR-1:0] frac);
      logic [FR:0] wide;
      wide = {1'b0, frac};
      return frac[FR-1] ? (ONE_OUT - wide) : wide;
   endfunction

   // nearest integer, halves away from zero, modulo 2^OUT_W
   function automatic logic [OW-1:0] round_int(input logic [FW-1:0] mag_val,
                                               input logic neg);
      logic [OW-1:0] m;
      m = mag_val[FR +: OW] + OW'(mag_val[FR-1]);
      return neg ? (OW'(0) - m) : m;
   endfunction

   // configuration registers
   logic signed [pth_pkg::ORIGIN_W-1:0] origin_x_ff;
   logic signed [pth_pkg::ORIGIN_W-1:0] origin_y_ff;
   logic [pth_pkg::INV_W-1:0]           inv_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         inv_radius_ff <= pth_pkg::INV_RADIUS_RST;
      end else if (csr_we) begin
         unique case (pth_pkg::csr_index_type'(csr_index))
            pth_pkg::CSR_ORIGIN_X:   origin_x_ff   <= $signed(csr_wdata);
            pth_pkg::CSR_ORIGIN_Y:   origin_y_ff   <= $signed(csr_wdata);
            pth_pkg::CSR_INV_RADIUS: inv_radius_ff <= csr_wdata[pth_pkg::INV_W-1:0];
            default: ;
         endcase
      end
   end

   // stage valids and load enables
   logic [ST:1]   valid_ff;
   logic [ST:1]   valid_in;
   logic [ST+1:1] en;

   always_comb begin
      en[ST+1] = rsp_ch.ready;
      for (int k = ST; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[1] = req_ch.valid;
      for (int k = 2; k <= ST; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= ST; k++) begin
            if (en[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   assign req_ch.ready = en[1];
   assign rsp_ch.valid = valid_ff[ST];

   // stage 1: offset from grid origin, 4 fraction bits
   logic signed [DW-1:0] dx_ff, dy_ff, dx_in, dy_in;

   always_comb begin
      dx_in = DW'($signed({1'b0, req_ch.pixel_x, 4'b0000})) - DW'(origin_x_ff);
      dy_in = DW'($signed({1'b0, req_ch.pixel_y, 4'b0000})) - DW'(origin_y_ff);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // stage 2: scale by reciprocal radius, 20 fraction bits
   logic signed [UW-1:0] u_ff, v_ff, u_in, v_in, inv_s;

   always_comb begin
      inv_s = UW'($signed({1'b0, inv_radius_ff}));
      u_in  = UW'(dx_ff) * inv_s;
      v_in  = UW'(dy_ff) * inv_s;
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         u_ff <= u_in;
         v_ff <= v_in;
      end
   end

   // stage 3: constant products, 40 fraction bits
   logic signed [PW-1:0] pxu_ff, pzv_ff, pzu_ff, pxu_in, pzv_in, pzu_in;

   always_comb begin
      pxu_in = PW'(u_ff) * PW'(pth_pkg::K_TWO_THIRDS);
      pzv_in = PW'(v_ff) * PW'(pth_pkg::K_INV_SQRT3);
      pzu_in = PW'(u_ff) * PW'(pth_pkg::K_ONE_THIRD);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         pxu_ff <= pxu_in;
         pzv_ff <= pzv_in;
         pzu_ff <= pzu_in;
      end
   end

   // stage 4: fractional cube coordinates
   logic signed [FW-1:0] xf_ff, yf_ff, zf_ff, xf_in, yf_in, zf_in;

   always_comb begin
      xf_in = FW'(pxu_ff);
      zf_in = FW'(pzv_ff) - FW'(pzu_ff);
      yf_in = FW'(pzu_ff) - FW'(pzv_ff) - FW'(pxu_ff);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         xf_ff <= xf_in;
         yf_ff <= yf_in;
         zf_ff <= zf_in;
      end
   end

   // stage 5: sign and magnitude
   logic [FW-1:0] mag_x_ff, mag_y_ff, mag_z_ff, mag_x_in, mag_y_in, mag_z_in;
   logic          neg_x_ff, neg_y_ff, neg_z_ff;

   always_comb begin
      mag_x_in = xf_ff[FW-1] ? $unsigned(-xf_ff) : $unsigned(xf_ff);
      mag_y_in = yf_ff[FW-1] ? $unsigned(-yf_ff) : $unsigned(yf_ff);
      mag_z_in = zf_ff[FW-1] ? $unsigned(-zf_ff) : $unsigned(zf_ff);
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
         mag_z_ff <= mag_z_in;
         neg_x_ff <= xf_ff[FW-1];
         neg_y_ff <= yf_ff[FW-1];
         neg_z_ff <= zf_ff[FW-1];
      end
   end

   // stage 6: rounded coordinates and their rounding errors
   logic [OW-1:0] rx_ff, ry_ff, rz_ff;
   logic [FR:0]   ex_ff, ey_ff, ez_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         rx_ff <= round_int(mag_x_ff, neg_x_ff);
         ry_ff <= round_int(mag_y_ff, neg_y_ff);
         rz_ff <= round_int(mag_z_ff, neg_z_ff);
         ex_ff <= round_err(mag_x_ff[FR-1:0]);
         ey_ff <= round_err(mag_y_ff[FR-1:0]);
         ez_ff <= round_err(mag_z_ff[FR-1:0]);
      end
   end

   // stage 7: rebuild the worst component so the three sum to zero
   logic [OW-1:0] hex_q_ff, hex_r_ff, hex_q_in, hex_r_in;

   always_comb begin
      hex_q_in = rx_ff;
      hex_r_in = rz_ff;
      if (ex_ff > ey_ff && ex_ff > ez_ff) begin
         hex_q_in = OW'(0) - ry_ff - rz_ff;
      end else if (ey_ff > ez_ff) begin
         hex_q_in = rx_ff;
      end else begin
         hex_r_in = OW'(0) - rx_ff - ry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         hex_q_ff <= hex_q_in;
         hex_r_ff <= hex_r_in;
      end
   end

   assign rsp_ch.hex_q = $signed(hex_q_ff);
   assign rsp_ch.hex_r = $signed(hex_r_ff);

   // checks
   // request side stalls only when every stage holds an item
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (&valid_ff))
      else $error("request stalled with an empty stage");

   // reset leaves the pipeline empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   // rounding error never exceeds one half
   a_err_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] |-> (ex_ff <= (ONE_OUT >> 1) && ey_ff <= (ONE_OUT >> 1)
                       && ez_ff <= (ONE_OUT >> 1)))
      else $error("rounding error above one half");

endmodule
